// ----- src/chiptune_voice_synth_adsr_defines.svh -----
// Assertion macros shared by the voice synth RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef CHIPTUNE_VOICE_SYNTH_ADSR_DEFINES_SVH
`define CHIPTUNE_VOICE_SYNTH_ADSR_DEFINES_SVH

// same-cycle implication
`define CVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cvs assertion failed");

// next-cycle implication
`define CVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cvs assertion failed");

`endif

// ----- src/cvs_pkg.sv -----
// Types, codes and constant tables of the voice synth.
// Used by every module of the block; depends on nothing.
package cvs_pkg;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_TRIGGER = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_SILENCE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_SAW      = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_NOISE    = 2'd3
    } wave_t;

    typedef enum logic [2:0] {
        ENV_OFF     = 3'd0,
        ENV_ATTACK  = 3'd1,
        ENV_DECAY   = 3'd2,
        ENV_SUSTAIN = 3'd3,
        ENV_RELEASE = 3'd4
    } env_stage_t;

    typedef enum logic [1:0] {
        DIV_RISE = 2'd0,
        DIV_FALL = 2'd1,
        DIV_REL  = 2'd2
    } div_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_WAVE,
        ST_ENV,
        ST_DSTART,
        ST_DWAIT,
        ST_MUL,
        ST_ACC,
        ST_MIX1,
        ST_MIX2,
        ST_MIX3,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic [3:0] duty;
        logic [3:0] rel;
        logic [3:0] sustain;
        logic [3:0] decay;
        logic [3:0] attack;
        logic [1:0] wave;
    } voice_params_t;

    typedef struct packed {
        logic take;
        logic noise;
        logic wave;
        logic env;
        logic div_start;
        logic div_wr;
        logic mul;
        logic acc;
        logic vnext;
        logic mix1;
        logic mix2;
        logic mix3;
        logic out_load;
    } cvs_cmd_t;

    typedef struct packed {
        logic tick_in;
        logic voice_on_cur;
        logic last_voice;
        logic need_div;
        logic div_done;
        logic out_free;
    } cvs_status_t;

    localparam int NUM_W = 31;
    localparam int DEN_W = 14;
    localparam int QUO_W = 17;

    localparam logic [16:0] LEVEL_FULL = 17'd65536;
    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_INC    = 32'd1013904223;
    // smallest magnitude that already saturates after the 6600/2^31 scale
    localparam logic [33:0] MIX_CLAMP  = 34'd9761289310;
    localparam logic [13:0] LEN_UNIT   = 14'd1000;

    localparam logic [31:0] SEED_INIT [4] = '{32'd12345, 32'd54321, 32'd11111, 32'd99999};

    localparam logic [15:0] SQ_THR [16] = '{
        16'd6554,  16'd10049, 16'd13544, 16'd17039,
        16'd20535, 16'd24030, 16'd27525, 16'd31020,
        16'd34516, 16'd38011, 16'd41506, 16'd45001,
        16'd48497, 16'd51992, 16'd55487, 16'd58982
    };

    localparam logic [16:0] SUSTAIN_LVL [16] = '{
        17'd0,     17'd4369,  17'd8738,  17'd13107,
        17'd17476, 17'd21845, 17'd26214, 17'd30583,
        17'd34953, 17'd39322, 17'd43691, 17'd48060,
        17'd52429, 17'd56798, 17'd61167, 17'd65536
    };

    // volume zero means full scale
    localparam logic [16:0] VOLUME_LVL [16] = '{
        17'd65536, 17'd4369,  17'd8738,  17'd13107,
        17'd17476, 17'd21845, 17'd26214, 17'd30583,
        17'd34952, 17'd39321, 17'd43690, 17'd48059,
        17'd52428, 17'd56797, 17'd61166, 17'd65536
    };

    function automatic logic [21:0] semi_step(input logic [3:0] idx);
        logic [21:0] r;
        unique case (idx)
            4'd0:    r = 22'd1592508;
            4'd1:    r = 22'd1687262;
            4'd2:    r = 22'd1787590;
            4'd3:    r = 22'd1893810;
            4'd4:    r = 22'd2006400;
            4'd5:    r = 22'd2125679;
            4'd6:    r = 22'd2252124;
            4'd7:    r = 22'd2386054;
            4'd8:    r = 22'd2527947;
            4'd9:    r = 22'd2678279;
            4'd10:   r = 22'd2837530;
            4'd11:   r = 22'd3006177;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/chiptune_voice_synth_adsr.sv -----
// Top level of the four-voice chip sound generator with ADSR envelopes.
// Depends on cvs_pkg, cvs_ctrl and cvs_dp.
//
// Input channel (in_valid/in_stall): one word per item; mode selects tick,
// trigger, release or silence. Trigger, release and silence words are applied
// in the cycle they are accepted and return nothing; the next word may follow
// in the following cycle.
// A tick word returns one output word (sample, active_mask) on out_valid.
// Per tick, each voice in turn is skipped when silent, runs the wave, envelope,
// multiply and accumulate steps when its envelope level needs no ramp, and also
// waits on the shared restoring divider when it does; then the mix steps follow.
// in_stall stays high while a tick is in work; one item is in work at a time.
// The output word sits in a register; a new item is taken while it waits.
// If the receiver stalls, a finished tick holds until out_stall drops.
// Reset clears every voice (off, level zero), loads the noise seeds and
// empties the output register; no clearing pass is needed.
module chiptune_voice_synth_adsr
    import cvs_pkg::*;
#(
    parameter int VOICES     = 4,
    parameter int PHASE_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [1:0]         channel,
    input  logic [6:0]         note,
    input  logic [3:0]         volume,
    input  logic [1:0]         wave,
    input  logic [3:0]         attack,
    input  logic [3:0]         decay,
    input  logic [3:0]         sustain,
    input  logic [3:0]         release_req,
    input  logic [3:0]         duty,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample,
    output logic [3:0]         active_mask
);

    cvs_cmd_t    cmd;
    cvs_status_t status;

    cvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    cvs_dp #(
        .VOICES     (VOICES),
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (mode),
        .channel     (channel),
        .note        (note),
        .volume      (volume),
        .wave        (wave),
        .attack      (attack),
        .decay       (decay),
        .sustain     (sustain),
        .release_req (release_req),
        .duty        (duty),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .sample      (sample),
        .active_mask (active_mask)
    );

endmodule

// ----- src/cvs_div.sv -----
// Restoring divider, one quotient bit per cycle, for envelope ramps.
// Depends on cvs_pkg; the quotient is known to fit QUO_W bits.
module cvs_div
    import cvs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] den_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, q_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = diff[DEN_W-1:0];
            q_next   = {q_reg[QUO_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DEN_W-1:0];
            q_next   = {q_reg[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'(QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 5'd1;
            busy_reg <= (cnt_reg != 5'd1);
        end
    end

    // high part of the numerator is already below the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:QUO_W];
            q_reg   <= num[QUO_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

// ----- src/cvs_dp.sv -----
// Datapath of the voice synth: voice state, wave and envelope math, mixer, output word.
// Depends on cvs_pkg and cvs_div; driven by cvs_ctrl through cvs_cmd_t.
module cvs_dp
    import cvs_pkg::*;
#(
    parameter int VOICES     = 4,
    parameter int PHASE_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cvs_cmd_t           cmd,
    output cvs_status_t        status,
    input  logic [1:0]         mode,
    input  logic [1:0]         channel,
    input  logic [6:0]         note,
    input  logic [3:0]         volume,
    input  logic [1:0]         wave,
    input  logic [3:0]         attack,
    input  logic [3:0]         decay,
    input  logic [3:0]         sustain,
    input  logic [3:0]         release_req,
    input  logic [3:0]         duty,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [15:0] sample,
    output logic [3:0]         active_mask
);

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SUM_W  = 35 + $clog2(VOICES);

    logic [PHASE_BITS-1:0] phase_reg [VOICES];
    logic [PHASE_BITS-1:0] step_reg  [VOICES];
    env_stage_t            stage_reg [VOICES];
    logic [15:0]           timer_reg [VOICES];
    logic [16:0]           level_reg [VOICES];
    logic [16:0]           rel_reg   [VOICES];
    voice_params_t         prm_reg   [VOICES];
    logic [31:0]           seed_reg  [VOICES];
    logic [VOICES-1:0]     on_reg;

    logic [VIDX_W-1:0]        vidx_reg;
    logic signed [15:0]       s_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DEN_W-1:0]         den_reg;
    div_kind_t                kind_reg;
    logic signed [33:0]       prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [33:0]              mag_reg;
    logic [46:0]              part_reg;
    logic signed [15:0]       res_reg;
    logic                     out_valid_reg;
    logic signed [15:0]       sample_reg;
    logic [3:0]               mask_reg;

    // input decode
    logic [VIDX_W-1:0] ch_idx;
    logic              ch_ok;
    logic [6:0]        note_m1;
    logic [12:0]       oct_prod;
    logic [3:0]        oct;
    logic [7:0]        semi_full;
    logic [21:0]       semi_base;
    logic [41:0]       step_wide;
    voice_params_t     prm_in;

    assign ch_idx    = VIDX_W'(channel);
    assign ch_ok     = ({3'b000, channel} < 5'(VOICES));
    assign note_m1   = note - 7'd1;
    assign oct_prod  = 13'(note_m1) * 13'd43;
    assign oct       = oct_prod[12:9];
    assign semi_full = {1'b0, note_m1} - 8'(oct) * 8'd12;
    assign semi_base = semi_step(semi_full[3:0]) >> (32 - PHASE_BITS);
    assign step_wide = (note == 7'd0) ? 42'd0 : (42'(semi_base) << oct);
    assign prm_in    = '{duty: duty, rel: release_req, sustain: sustain, decay: decay,
                         attack: attack, wave: wave};

    // current voice read port
    logic [VIDX_W-1:0]     rd_idx;
    logic [PHASE_BITS-1:0] cur_phase;
    env_stage_t            cur_stage;
    logic [15:0]           cur_timer;
    logic [16:0]           cur_level;
    logic [16:0]           cur_rel;
    voice_params_t         cur_prm;
    logic [31:0]           cur_seed;

    assign rd_idx    = cmd.take ? ch_idx : vidx_reg;
    assign cur_phase = phase_reg[rd_idx];
    assign cur_stage = stage_reg[rd_idx];
    assign cur_timer = timer_reg[rd_idx];
    assign cur_level = level_reg[rd_idx];
    assign cur_rel   = rel_reg[rd_idx];
    assign cur_prm   = prm_reg[rd_idx];
    assign cur_seed  = seed_reg[rd_idx];

    // wave generation
    logic [31:0]        seed_new;
    logic [15:0]        p;
    logic signed [17:0] tri_lo;
    logic signed [17:0] tri_hi;
    logic signed [15:0] wave_val;

    assign seed_new = 32'(cur_seed * LCG_MUL) + LCG_INC;
    assign p        = cur_phase[PHASE_BITS-1 -: 16];
    assign tri_lo   = $signed({1'b0, p, 1'b0}) - 18'sd32768;
    assign tri_hi   = 18'sd98304 - $signed({1'b0, p, 1'b0});

    always_comb
    begin
        unique case (wave_t'(cur_prm.wave))
            WAVE_SQUARE:   wave_val = (p < SQ_THR[cur_prm.duty]) ? 16'sd32767 : -16'sd32767;
            WAVE_SAW:      wave_val = $signed({~p[15], p[14:0]});
            WAVE_TRIANGLE:
            begin
                if (!p[15])
                    wave_val = tri_lo[15:0];
                else if (tri_hi > 18'sd32767)
                    wave_val = 16'sd32767;
                else
                    wave_val = tri_hi[15:0];
            end
            default:       wave_val = $signed(cur_seed[31:16]);
        endcase
    end

    // envelope step
    logic [13:0]  a_len, d_len, r_len;
    logic [16:0]  sv;
    env_stage_t   stage_new;
    logic [15:0]  t_new;
    logic [15:0]  timer_new;
    logic [16:0]  lvl_new;
    logic         lvl_wr;
    logic         on_clr;
    logic         need_div;
    logic [16:0]  op_a;
    logic [13:0]  op_b;
    logic [13:0]  den_new;
    div_kind_t    kind_new;

    assign a_len = 14'(cur_prm.attack) * LEN_UNIT;
    assign d_len = 14'(cur_prm.decay) * LEN_UNIT;
    assign r_len = 14'(cur_prm.rel) * LEN_UNIT;
    assign sv    = SUSTAIN_LVL[cur_prm.sustain];

    always_comb
    begin
        stage_new = cur_stage;
        t_new     = cur_timer;
        lvl_new   = cur_level;
        lvl_wr    = 1'b0;
        on_clr    = 1'b0;
        need_div  = 1'b0;
        op_a      = LEVEL_FULL;
        op_b      = cur_timer[13:0];
        den_new   = a_len;
        kind_new  = DIV_RISE;
        unique case (cur_stage)
            ENV_ATTACK:
            begin
                if (a_len == 14'd0)
                begin
                    lvl_new = LEVEL_FULL; lvl_wr = 1'b1; stage_new = ENV_DECAY;
                end
                else if (cur_timer >= 16'(a_len))
                begin
                    lvl_new = LEVEL_FULL; lvl_wr = 1'b1; stage_new = ENV_DECAY;
                    t_new = 16'd0;
                end
                else
                    need_div = 1'b1;
            end
            ENV_DECAY:
            begin
                op_a     = LEVEL_FULL - sv;
                den_new  = d_len;
                kind_new = DIV_FALL;
                if (d_len == 14'd0)
                begin
                    lvl_new = sv; lvl_wr = 1'b1; stage_new = ENV_SUSTAIN;
                end
                else if (cur_timer >= 16'(d_len))
                begin
                    lvl_new = sv; lvl_wr = 1'b1; stage_new = ENV_SUSTAIN;
                    t_new = 16'd0;
                end
                else
                    need_div = 1'b1;
            end
            ENV_SUSTAIN:
            begin
                lvl_new = sv; lvl_wr = 1'b1;
            end
            ENV_RELEASE:
            begin
                op_a     = cur_rel;
                op_b     = r_len - cur_timer[13:0];
                den_new  = r_len;
                kind_new = DIV_REL;
                if (r_len == 14'd0 || cur_timer >= 16'(r_len))
                begin
                    lvl_new = 17'd0; lvl_wr = 1'b1; on_clr = 1'b1;
                end
                else
                    need_div = 1'b1;
            end
            default:
            begin
                lvl_wr = 1'b0;
            end
        endcase
        timer_new = (t_new != 16'hFFFF) ? t_new + 16'd1 : 16'hFFFF;
    end

    logic             div_busy;
    logic [QUO_W-1:0] div_quo;

    cvs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (den_reg),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    logic signed [33:0]      prod_next;
    logic [SUM_W-1:0]        mag_full;
    logic [46:0]             tot;
    logic [15:0]             res_mag;
    logic [3:0]              mask_w;

    assign prod_next = 34'(s_reg) * $signed(34'(cur_level));
    assign mag_full  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign tot       = part_reg + (47'(mag_reg) << 7) + (47'(mag_reg) << 6)
                     + (47'(mag_reg) << 3);
    assign res_mag   = {1'b0, tot[45:31]};

    for (genvar g = 0; g < 4; g++)
    begin : g_mask
        if (g < VOICES)
        begin : g_on
            assign mask_w[g] = on_reg[g];
        end
        else
        begin : g_off
            assign mask_w[g] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                phase_reg[i] <= '0;
                step_reg[i]  <= '0;
                stage_reg[i] <= ENV_OFF;
                timer_reg[i] <= '0;
                level_reg[i] <= '0;
                rel_reg[i]   <= '0;
                prm_reg[i]   <= '0;
                seed_reg[i]  <= SEED_INIT[2'(i)];
            end
            on_reg        <= '0;
            vidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                unique case (mode_t'(mode))
                    MODE_TRIGGER:
                    begin
                        if (ch_ok)
                        begin
                            step_reg[ch_idx]  <= step_wide[PHASE_BITS-1:0];
                            prm_reg[ch_idx]   <= prm_in;
                            phase_reg[ch_idx] <= '0;
                            stage_reg[ch_idx] <= ENV_ATTACK;
                            timer_reg[ch_idx] <= '0;
                            level_reg[ch_idx] <= '0;
                            rel_reg[ch_idx]   <= VOLUME_LVL[volume];
                            on_reg[ch_idx]    <= (note != 7'd0);
                        end
                    end
                    MODE_RELEASE:
                    begin
                        if (ch_ok)
                        begin
                            stage_reg[ch_idx] <= ENV_RELEASE;
                            timer_reg[ch_idx] <= '0;
                            rel_reg[ch_idx]   <= cur_level;
                        end
                    end
                    MODE_SILENCE:
                    begin
                        for (int i = 0; i < VOICES; i++)
                        begin
                            stage_reg[i] <= ENV_OFF;
                            level_reg[i] <= '0;
                        end
                        on_reg <= '0;
                    end
                    default:
                    begin
                        vidx_reg <= '0;
                    end
                endcase
            end
            if (cmd.noise && wave_t'(cur_prm.wave) == WAVE_NOISE)
                seed_reg[vidx_reg] <= seed_new;
            if (cmd.env)
            begin
                stage_reg[vidx_reg] <= stage_new;
                timer_reg[vidx_reg] <= timer_new;
                if (lvl_wr)
                    level_reg[vidx_reg] <= lvl_new;
                if (on_clr)
                    on_reg[vidx_reg] <= 1'b0;
            end
            if (cmd.div_wr)
                level_reg[vidx_reg] <= (kind_reg == DIV_FALL) ? LEVEL_FULL - div_quo : div_quo;
            if (cmd.acc)
                phase_reg[vidx_reg] <= cur_phase + step_reg[vidx_reg];
            if (cmd.vnext)
                vidx_reg <= vidx_reg + VIDX_W'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && mode_t'(mode) == MODE_TICK)
            sum_reg <= '0;
        else if (cmd.acc)
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        if (cmd.wave)
            s_reg <= wave_val;
        if (cmd.env)
        begin
            num_reg  <= NUM_W'(op_a) * NUM_W'(op_b);
            den_reg  <= den_new;
            kind_reg <= kind_new;
        end
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.mix1)
            mag_reg <= (mag_full > SUM_W'(MIX_CLAMP)) ? MIX_CLAMP : mag_full[33:0];
        if (cmd.mix2)
            part_reg <= (47'(mag_reg) << 12) + (47'(mag_reg) << 11) + (47'(mag_reg) << 8);
        if (cmd.mix3)
            res_reg <= sum_reg[SUM_W-1] ? $signed(-res_mag) : $signed(res_mag);
        if (cmd.out_load)
        begin
            sample_reg <= res_reg;
            mask_reg   <= mask_w;
        end
    end

    assign status.tick_in      = (mode_t'(mode) == MODE_TICK);
    assign status.voice_on_cur = on_reg[vidx_reg];
    assign status.last_voice   = (vidx_reg == VIDX_W'(VOICES - 1));
    assign status.need_div     = need_div;
    assign status.div_done     = !div_busy;
    assign status.out_free     = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign active_mask = mask_reg;

endmodule

// ----- src/cvs_ctrl.sv -----
// Sequencer of the voice synth: walks the voices for a tick and drives the datapath.
// Depends on cvs_pkg and the assertion macros header.
`include "chiptune_voice_synth_adsr_defines.svh"

module cvs_ctrl
    import cvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  cvs_status_t status,
    output cvs_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.tick_in)
                        state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (status.voice_on_cur)
                begin
                    cmd.noise  = 1'b1;
                    state_next = ST_WAVE;
                end
                else
                begin
                    cmd.vnext  = 1'b1;
                    state_next = status.last_voice ? ST_MIX1 : ST_CHK;
                end
            end
            ST_WAVE:
            begin
                cmd.wave   = 1'b1;
                state_next = ST_ENV;
            end
            ST_ENV:
            begin
                cmd.env    = 1'b1;
                state_next = status.need_div ? ST_DSTART : ST_MUL;
            end
            ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_wr = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                cmd.vnext  = 1'b1;
                state_next = status.last_voice ? ST_MIX1 : ST_CHK;
            end
            ST_MIX1:
            begin
                cmd.mix1   = 1'b1;
                state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                cmd.mix2   = 1'b1;
                state_next = ST_MIX3;
            end
            ST_MIX3:
            begin
                cmd.mix3   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    `CVS_ASSERT_NOW(a_div_start_idle, clk, rst_n, cmd.div_start, status.div_done)
    `CVS_ASSERT_NOW(a_load_free, clk, rst_n, cmd.out_load, status.out_free)
    `CVS_ASSERT_NEXT(a_tick_walks, clk, rst_n, cmd.take && status.tick_in, state_reg == ST_CHK)
    `CVS_ASSERT_NEXT(a_div_runs, clk, rst_n, cmd.div_start, !status.div_done)

endmodule
